// ===== rtl/qot_pkg.sv =====
`default_nettype none

package qot_pkg;

	// Coordinate and arithmetic widths.
	localparam int COORD_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	// Configuration register map.
	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_A_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_Y = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_X = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_Y = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C_X = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C_Y = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_D_X = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_D_Y = 4'd7;

	// The edge terms of a corner test are indexed 0..5: triangle ABC in 0..2, triangle ACD in 3..5.
	// A term is the cross product (p - r) x (q - r) for corner indexes q and r.
	localparam int NUM_TERMS = 6;
	localparam int TERM_Q [NUM_TERMS] = '{0, 1, 2, 0, 2, 3};
	localparam int TERM_R [NUM_TERMS] = '{1, 2, 0, 2, 3, 0};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef point_t [3:0] quad_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] other_a_x;
		logic signed [COORD_W-1:0] other_a_y;
		logic signed [COORD_W-1:0] other_b_x;
		logic signed [COORD_W-1:0] other_b_y;
		logic signed [COORD_W-1:0] other_c_x;
		logic signed [COORD_W-1:0] other_c_y;
		logic signed [COORD_W-1:0] other_d_x;
		logic signed [COORD_W-1:0] other_d_y;
	} in_item_t;

	typedef struct packed {
		logic collide;
		logic ref_corner_inside;
		logic other_corner_inside;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/qot_lane.sv =====
`default_nettype none

// Tests one corner against one quad over three pipeline stages.
module qot_lane import qot_pkg::*; (
	input  wire logic   clk,
	input  wire point_t pt,
	input  wire quad_t  quad,
	output logic        hit
);

	logic signed [DIFF_W-1:0]  ux_s1 [NUM_TERMS];
	logic signed [DIFF_W-1:0]  uy_s1 [NUM_TERMS];
	logic signed [DIFF_W-1:0]  vx_s1 [NUM_TERMS];
	logic signed [DIFF_W-1:0]  vy_s1 [NUM_TERMS];
	logic signed [PROD_W-1:0]  p1_s2 [NUM_TERMS];
	logic signed [PROD_W-1:0]  p2_s2 [NUM_TERMS];
	logic [NUM_TERMS-1:0]      neg_s3;
	logic [NUM_TERMS-1:0]      pos_s3;

	for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
		logic signed [CROSS_W-1:0] diff;

		// Stage 1: edge vectors relative to corner r.
		always_ff @(posedge clk) begin
			ux_s1[t] <= DIFF_W'(pt.x) - DIFF_W'(quad[TERM_R[t]].x);
			uy_s1[t] <= DIFF_W'(pt.y) - DIFF_W'(quad[TERM_R[t]].y);
			vx_s1[t] <= DIFF_W'(quad[TERM_Q[t]].x) - DIFF_W'(quad[TERM_R[t]].x);
			vy_s1[t] <= DIFF_W'(quad[TERM_Q[t]].y) - DIFF_W'(quad[TERM_R[t]].y);
		end

		// Stage 2: the two partial products of the cross product.
		always_ff @(posedge clk) begin
			p1_s2[t] <= ux_s1[t] * vy_s1[t];
			p2_s2[t] <= vx_s1[t] * uy_s1[t];
		end

		// Stage 3: exact difference reduced to its sign.
		assign diff = CROSS_W'(p1_s2[t]) - CROSS_W'(p2_s2[t]);

		always_ff @(posedge clk) begin
			neg_s3[t] <= diff[CROSS_W-1];
			pos_s3[t] <= !diff[CROSS_W-1] && (diff != '0);
		end
	end

	// A triangle contains the corner unless its terms disagree in strict sign.
	logic in_abc;
	logic in_acd;

	assign in_abc = !((|neg_s3[2:0]) && (|pos_s3[2:0]));
	assign in_acd = !((|neg_s3[5:3]) && (|pos_s3[5:3]));
	assign hit = in_abc || in_acd;

endmodule

`default_nettype wire

// ===== rtl/qot_merge.sv =====
`default_nettype none

// Combines the eight lane hits into the result item.
module qot_merge import qot_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       vld,
	input  wire logic [3:0] ref_hits,
	input  wire logic [3:0] other_hits,
	output logic            done,
	output out_item_t       result
);

	logic      done_q;
	out_item_t result_q;

	// Strobe for the finished item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		result_q.ref_corner_inside <= |ref_hits;
		result_q.other_corner_inside <= |other_hits;
		result_q.collide <= (|ref_hits) || (|other_hits);
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/quad_overlap_test_core.sv =====
`default_nettype none

// Quad overlap test core.
// The reference quad (corners A, B, C, D) is loaded through the configuration
// channel: cfg_index selects one coordinate (A.x, A.y, B.x, ... D.y as 0..7)
// and cfg_data carries its signed Q12.4 value. cfg_ready is always high and
// indexes beyond the register map are ignored. Load it while no item is in
// flight.
// An item is accepted on each clock edge where start is high; busy is never
// raised, so one item can be accepted every cycle. Each item carries the four
// corners of the tested quad.
// Eight lanes each test one corner (four reference corners against the tested
// quad, four tested corners against the reference quad) through a three-stage
// pipeline of edge vectors, products and sign checks; a merge register follows.
// done and the result are registered together in the merge register behind the
// last lane stage, and the pipeline takes one item per cycle.
// The receiver cannot stall, so results are never held.
// Reset clears the reference quad to all zero corners (every point then counts
// as inside) and drops any items in flight.
module quad_overlap_test_core import qot_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             item,
	output logic                      done,
	output out_item_t                 result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data
);

	quad_t      ref_q;
	quad_t      other_quad;
	logic       accept;
	logic       vld_s1;
	logic       vld_s2;
	logic       vld_s3;
	logic [3:0] ref_hits;
	logic [3:0] other_hits;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	// Reference quad registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_A_X: ref_q[0].x <= cfg_data;
				REG_A_Y: ref_q[0].y <= cfg_data;
				REG_B_X: ref_q[1].x <= cfg_data;
				REG_B_Y: ref_q[1].y <= cfg_data;
				REG_C_X: ref_q[2].x <= cfg_data;
				REG_C_Y: ref_q[2].y <= cfg_data;
				REG_D_X: ref_q[3].x <= cfg_data;
				REG_D_Y: ref_q[3].y <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tested quad as a corner array.
	assign other_quad[0] = '{x: item.other_a_x, y: item.other_a_y};
	assign other_quad[1] = '{x: item.other_b_x, y: item.other_b_y};
	assign other_quad[2] = '{x: item.other_c_x, y: item.other_c_y};
	assign other_quad[3] = '{x: item.other_d_x, y: item.other_d_y};

	// Item valid travels alongside the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Corner lanes in both directions.
	for (genvar i = 0; i < 4; i++) begin : g_lane
		qot_lane u_ref_lane (
			.clk  (clk),
			.pt   (ref_q[i]),
			.quad (other_quad),
			.hit  (ref_hits[i])
		);

		qot_lane u_other_lane (
			.clk  (clk),
			.pt   (other_quad[i]),
			.quad (ref_q),
			.hit  (other_hits[i])
		);
	end

	qot_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld        (vld_s3),
		.ref_hits   (ref_hits),
		.other_hits (other_hits),
		.done       (done),
		.result     (result)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted item did not complete after four cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s3))
		else $error("result strobe without an item in the last stage");

	a_collide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.collide == (result.ref_corner_inside || result.other_corner_inside))
		else $error("collide disagrees with the corner flags");

	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && ref_q == '0 && $past(ref_q == '0, 3) |=> result.collide)
		else $error("all-zero reference quad must report a collision");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_quad_overlap_test_core.sv =====
`timescale 1ns / 100ps

module tb_quad_overlap_test_core;
	import qot_pkg::*;

	localparam int CMAX = 2 ** (COORD_W - 1) - 1;
	localparam int CMIN = -(2 ** (COORD_W - 1));

	// Shapes used for the reference quad from one phase to the next.
	typedef enum {REF_RECT, REF_FULL, REF_RANDOM, REF_LINE, REF_POINT, REF_TINY} ref_shape_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             item = '0;
	logic                 done;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;

	// Tested quads waiting to be sent, and overlap verdicts waiting to come back.
	in_item_t  pending [$];
	out_item_t overlap_due [$];

	// Reference quad as the block holds it, tracked from accepted writes.
	quad_t ref_quad = '0;

	// Reference quad as the stimulus last set it, with its center and reach.
	quad_t ref_set = '0;
	int    ctr_x = 0;
	int    ctr_y = 0;
	int    reach = 1;

	int  mismatches = 0;
	bit  took = 1'b0;
	int  burst_left = 1;
	int  gap_left = 0;

	quad_overlap_test_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Sign of the cross product (p - r) x (q - r), formed at full width.
	function automatic int edge_side(point_t p, point_t q, point_t r);
		logic signed [DIFF_W-1:0]  ax, ay, bx, by;
		logic signed [PROD_W-1:0]  t1, t2;
		logic signed [CROSS_W-1:0] cr;
		ax = $signed(p.x) - $signed(r.x);
		ay = $signed(p.y) - $signed(r.y);
		bx = $signed(q.x) - $signed(r.x);
		by = $signed(q.y) - $signed(r.y);
		t1 = ax * by;
		t2 = bx * ay;
		cr = t1 - t2;
		if (cr < 0)
			return -1;
		if (cr == 0)
			return 0;
		return 1;
	endfunction

	// A point is outside a triangle only if the edge signs disagree strictly.
	function automatic bit tri_holds(point_t p, point_t a, point_t b, point_t c);
		int s [3];
		bit neg, pos;
		s[0] = edge_side(p, a, b);
		s[1] = edge_side(p, b, c);
		s[2] = edge_side(p, c, a);
		neg = s[0] < 0 || s[1] < 0 || s[2] < 0;
		pos = s[0] > 0 || s[1] > 0 || s[2] > 0;
		return !(neg && pos);
	endfunction

	function automatic bit quad_holds(point_t p, quad_t q);
		return tri_holds(p, q[0], q[1], q[2]) || tri_holds(p, q[0], q[2], q[3]);
	endfunction

	function automatic bit corner_in(quad_t pts, quad_t q);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < 4; i++)
			hit |= quad_holds(pts[i], q);
		return hit;
	endfunction

	function automatic out_item_t predict_overlap(quad_t rq, quad_t tq);
		out_item_t r;
		r.ref_corner_inside = corner_in(rq, tq);
		r.other_corner_inside = corner_in(tq, rq);
		r.collide = r.ref_corner_inside | r.other_corner_inside;
		return r;
	endfunction

	function automatic quad_t to_quad(in_item_t it);
		quad_t q;
		q[0] = '{x: it.other_a_x, y: it.other_a_y};
		q[1] = '{x: it.other_b_x, y: it.other_b_y};
		q[2] = '{x: it.other_c_x, y: it.other_c_y};
		q[3] = '{x: it.other_d_x, y: it.other_d_y};
		return q;
	endfunction

	function automatic in_item_t to_item(quad_t q);
		in_item_t it;
		it.other_a_x = q[0].x;
		it.other_a_y = q[0].y;
		it.other_b_x = q[1].x;
		it.other_b_y = q[1].y;
		it.other_c_x = q[2].x;
		it.other_c_y = q[2].y;
		it.other_d_x = q[3].x;
		it.other_d_y = q[3].y;
		return it;
	endfunction

	function automatic logic signed [COORD_W-1:0] clip(int v);
		if (v > CMAX)
			return COORD_W'(CMAX);
		if (v < CMIN)
			return COORD_W'(CMIN);
		return COORD_W'(v);
	endfunction

	function automatic int spread(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// Axis-aligned rectangle with jittered corners; flip reverses the winding.
	function automatic quad_t make_rect(int cx, int cy, int hw, int hh, int jit, bit flip);
		quad_t q;
		int xs [4];
		int ys [4];
		int k;
		xs = '{cx - hw, cx + hw, cx + hw, cx - hw};
		ys = '{cy - hh, cy - hh, cy + hh, cy + hh};
		for (int j = 0; j < 4; j++) begin
			k = flip ? (4 - j) % 4 : j;
			q[k].x = clip(xs[j] + spread(jit));
			q[k].y = clip(ys[j] + spread(jit));
		end
		return q;
	endfunction

	// Four corners evenly spaced on one line, all equal when the step is zero.
	function automatic quad_t make_line(int px, int py, int dx, int dy);
		quad_t q;
		for (int j = 0; j < 4; j++) begin
			q[j].x = clip(px + j * dx);
			q[j].y = clip(py + j * dy);
		end
		return q;
	endfunction

	// Random tested quad, mostly placed around the reference so that verdicts vary.
	function automatic quad_t tested_quad();
		quad_t q;
		int roll, hw, hh, jit, j2;
		roll = $urandom_range(0, 9);
		if (roll <= 5) begin
			hw = $urandom_range(1, 2 * reach);
			hh = $urandom_range(1, 2 * reach);
			jit = $urandom_range(0, 1) ? 0 : $urandom_range(0, (hw < hh ? hw : hh) / 4);
			q = make_rect(ctr_x + spread(2 * reach), ctr_y + spread(2 * reach), hw, hh, jit,
				$urandom_range(0, 1));
		end else if (roll == 6) begin
			// Noise over the whole coordinate range.
			for (int j = 0; j < 4; j++) begin
				q[j].x = COORD_W'($urandom);
				q[j].y = COORD_W'($urandom);
			end
		end else if (roll == 7) begin
			// Degenerate quad: a single point or collinear corners.
			if ($urandom_range(0, 1))
				q = make_line(ctr_x + spread(2 * reach), ctr_y + spread(2 * reach), 0, 0);
			else
				q = make_line(ctr_x + spread(2 * reach), ctr_y + spread(2 * reach),
					spread(reach), spread(reach));
		end else if (roll == 8) begin
			// Corners on or next to the reference corners and edge midpoints.
			q = ref_set;
			for (int j = 0; j < 4; j++) begin
				j2 = (j + 1) % 4;
				case ($urandom_range(0, 2))
					1: begin
						q[j].x = clip(int'(ref_set[j].x) + spread(2));
						q[j].y = clip(int'(ref_set[j].y) + spread(2));
					end
					2: begin
						q[j].x = clip((int'(ref_set[j].x) + int'(ref_set[j2].x)) / 2);
						q[j].y = clip((int'(ref_set[j].y) + int'(ref_set[j2].y)) / 2);
					end
					default: ;
				endcase
			end
		end else begin
			// Long thin bar across the reference, where edges cross without a corner inside.
			if ($urandom_range(0, 1))
				q = make_rect(ctr_x, ctr_y, 3 * reach + 1, reach / 4, 0, $urandom_range(0, 1));
			else
				q = make_rect(ctr_x, ctr_y, reach / 4, 3 * reach + 1, 0, $urandom_range(0, 1));
		end
		return q;
	endfunction

	function automatic quad_t reference_shape(ref_shape_e shape);
		quad_t q;
		int hw;
		case (shape)
			REF_RECT: begin
				hw = $urandom_range(16, 8000);
				q = make_rect(spread(16000), spread(16000), hw, $urandom_range(16, 8000),
					hw / 4, $urandom_range(0, 1));
			end
			REF_FULL:
				q = make_rect(0, 0, 2 * CMAX, 2 * CMAX, 0, $urandom_range(0, 1));
			REF_RANDOM:
				for (int j = 0; j < 4; j++) begin
					q[j].x = COORD_W'($urandom);
					q[j].y = COORD_W'($urandom);
				end
			REF_LINE:
				q = make_line(spread(16000), spread(16000), spread(2000), spread(2000));
			REF_POINT:
				q = make_line(spread(CMAX), spread(CMAX), 0, 0);
			default:
				q = make_rect(spread(16000), spread(16000), $urandom_range(1, 4),
					$urandom_range(1, 4), 0, $urandom_range(0, 1));
		endcase
		return q;
	endfunction

	// Load a reference quad through the configuration channel, with one stray
	// write past the register map dropped in at a random place.
	task automatic write_ref_quad(input quad_t q);
		logic [CFG_IDX_W-1:0] idx [$];
		logic [COORD_W-1:0]   val [$];
		int pos, min_x, max_x, min_y, max_y;
		idx = '{REG_A_X, REG_A_Y, REG_B_X, REG_B_Y, REG_C_X, REG_C_Y, REG_D_X, REG_D_Y};
		val = '{q[0].x, q[0].y, q[1].x, q[1].y, q[2].x, q[2].y, q[3].x, q[3].y};
		pos = $urandom_range(0, NUM_REGS);
		idx.insert(pos, CFG_IDX_W'(NUM_REGS + $urandom_range(0, 2 ** CFG_IDX_W - NUM_REGS - 1)));
		val.insert(pos, COORD_W'($urandom));
		foreach (idx[i]) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;

		// Remember where the reference sits so that tested quads can be aimed at it.
		ref_set = q;
		min_x = CMAX;
		max_x = CMIN;
		min_y = CMAX;
		max_y = CMIN;
		for (int j = 0; j < 4; j++) begin
			if (int'(q[j].x) < min_x) min_x = int'(q[j].x);
			if (int'(q[j].x) > max_x) max_x = int'(q[j].x);
			if (int'(q[j].y) < min_y) min_y = int'(q[j].y);
			if (int'(q[j].y) > max_y) max_y = int'(q[j].y);
		end
		ctr_x = (min_x + max_x) / 2;
		ctr_y = (min_y + max_y) / 2;
		reach = ((max_x - min_x > max_y - min_y) ? max_x - min_x : max_y - min_y) / 2 + 1;
	endtask

	task automatic send(input quad_t q);
		pending.push_back(to_item(q));
	endtask

	// Wait until every item is sent and every verdict has come back, then let
	// the pipeline run dry.
	task automatic drain();
		while (pending.size() != 0 || start || overlap_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Item driver: bursts of random length separated by random gaps, with noise
	// on the item bus while start is low.
	always @(negedge clk) begin : driver
		bit       go;
		in_item_t nxt;
		if (arst_n && (!start || took)) begin
			go = 1'b0;
			nxt = '0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() > 0) begin
				go = 1'b1;
				nxt = pending.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			start <= go;
			item <= go ? nxt : in_item_t'({$urandom, $urandom, $urandom, $urandom});
		end
	end

	// Monitor: track register writes, predict each accepted item, check each verdict.
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (!arst_n) begin
			took = 1'b0;
		end else begin
			took = start && !busy;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_A_X: ref_quad[0].x = cfg_data;
					REG_A_Y: ref_quad[0].y = cfg_data;
					REG_B_X: ref_quad[1].x = cfg_data;
					REG_B_Y: ref_quad[1].y = cfg_data;
					REG_C_X: ref_quad[2].x = cfg_data;
					REG_C_Y: ref_quad[2].y = cfg_data;
					REG_D_X: ref_quad[3].x = cfg_data;
					REG_D_Y: ref_quad[3].y = cfg_data;
					default: ;
				endcase
			end
			if (took)
				overlap_due.push_back(predict_overlap(ref_quad, to_quad(item)));
			if (done) begin
				if (overlap_due.size() == 0) begin
					$error("result with no item pending: collide %0b ref %0b other %0b",
						result.collide, result.ref_corner_inside, result.other_corner_inside);
					mismatches++;
				end else begin
					want = overlap_due.pop_front();
					if (result.collide !== want.collide) begin
						$error("collide: expected %0b, actual %0b", want.collide, result.collide);
						mismatches++;
					end
					if (result.ref_corner_inside !== want.ref_corner_inside) begin
						$error("ref_corner_inside: expected %0b, actual %0b",
							want.ref_corner_inside, result.ref_corner_inside);
						mismatches++;
					end
					if (result.other_corner_inside !== want.other_corner_inside) begin
						$error("other_corner_inside: expected %0b, actual %0b",
							want.other_corner_inside, result.other_corner_inside);
						mismatches++;
					end
				end
			end
		end
	end

	// Stimulus: directed cases first, then random phases over several references.
	initial begin : stimulus
		ref_shape_e plan [10];
		quad_t q;
		plan = '{REF_RECT, REF_FULL, REF_RANDOM, REF_RECT, REF_LINE,
			REF_TINY, REF_POINT, REF_RECT, REF_RANDOM, REF_RECT};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reference left at reset: all corners at the origin, so everything collides.
		for (int j = 0; j < 4; j++) begin
			q[j].x = COORD_W'($urandom);
			q[j].y = COORD_W'($urandom);
		end
		send(q);
		send(make_rect(0, 0, 2 * CMAX, 2 * CMAX, 0, 0));
		drain();

		// Square of side 20.0 around the origin.
		write_ref_quad(make_rect(0, 0, 160, 160, 0, 0));
		send(make_rect(0, 0, 160, 160, 0, 1));
		send(make_rect(0, 0, 16, 16, 0, 0));
		send(make_rect(0, 0, 1000, 1000, 0, 1));
		send(make_rect(1050, 1050, 50, 50, 0, 0));
		// Sharing an edge, then sharing only a corner.
		send(make_rect(230, 0, 70, 50, 0, 0));
		send(make_rect(230, 230, 70, 70, 0, 0));
		// Bar across the square: edges cross but no corner is inside.
		send(make_rect(0, 0, 400, 40, 0, 0));
		send(make_rect(0, 0, 2 * CMAX, 2 * CMAX, 0, 1));
		// Single-point quads: far away, on an edge, at the center.
		send(make_line(CMAX, CMAX, 0, 0));
		send(make_line(160, 0, 0, 0));
		send(make_line(0, 0, 0, 0));
		// Collinear corners on the diagonal through two reference corners.
		send(make_line(1000, 1000, 1000, 1000));
		// Diamond touching the coordinate extremes.
		q[0] = '{x: COORD_W'(CMIN), y: '0};
		q[1] = '{x: '0, y: COORD_W'(CMIN)};
		q[2] = '{x: COORD_W'(CMAX), y: '0};
		q[3] = '{x: '0, y: COORD_W'(CMAX)};
		send(q);
		drain();

		// Reference spanning the whole coordinate range.
		write_ref_quad(make_rect(0, 0, 2 * CMAX, 2 * CMAX, 0, 0));
		send(make_rect(0, 0, 2 * CMAX, 2 * CMAX, 0, 0));
		send(make_line(CMIN, CMIN, 0, 0));
		send(make_line(CMIN, CMAX, 0, 0));
		drain();

		foreach (plan[p]) begin
			write_ref_quad(reference_shape(plan[p]));
			repeat (128) send(tested_quad());
			drain();
		end

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== quad_overlap_test_core.f =====
rtl/qot_pkg.sv
rtl/qot_lane.sv
rtl/qot_merge.sv
rtl/quad_overlap_test_core.sv
verif/tb_quad_overlap_test_core.sv
